>>> rtl/can_motor_feedback_and_drive_frames_unit_macros.svh
// Assertion macros shared by the motor feedback and drive frame unit.
// No dependencies; included by the modules that check their own logic.
`ifndef CAN_MOTOR_FEEDBACK_AND_DRIVE_FRAMES_UNIT_MACROS_SVH
`define CAN_MOTOR_FEEDBACK_AND_DRIVE_FRAMES_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmfd assertion failed");

// Next-cycle implication, checked outside reset.
`define CMFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmfd assertion failed");

`endif

>>> rtl/cmfd_pkg.sv
// Types, codes and constants of the motor feedback and drive frame unit.
// No dependencies; imported by the controller, the datapath and the top level.
package cmfd_pkg;

    localparam int MOTOR_COUNT_DEF = 6;

    localparam logic [10:0] WHEEL_ID          = 11'h200;
    localparam logic [10:0] CLAMP_ID          = 11'h1FF;
    localparam logic [10:0] FEEDBACK_BASE     = 11'h200;
    localparam logic [3:0]  FRAME_BYTES       = 4'd8;
    localparam logic [3:0]  WHEEL_GROUP       = 4'd4;
    localparam logic [14:0] MAX_CURRENT_RESET = 15'd16384;

    // Command codes
    localparam logic [2:0] CMD_FRAME    = 3'd0;
    localparam logic [2:0] CMD_POLL     = 3'd1;
    localparam logic [2:0] CMD_WHEEL    = 3'd2;
    localparam logic [2:0] CMD_CLAMP    = 3'd3;
    localparam logic [2:0] CMD_TX_WHEEL = 3'd4;
    localparam logic [2:0] CMD_TX_CLAMP = 3'd5;

    // Status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic [10:0]        frame_id;
        logic [3:0]         frame_length;
        logic [63:0]        frame_data;
        logic [3:0]         motor;
        logic signed [15:0] drive_value;
        logic               query;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic               frame_valid;
        logic [10:0]        out_frame_id;
        logic [63:0]        out_frame_data;
        logic signed [15:0] speed;
        logic [15:0]        torque_current;
        logic [7:0]         temperature;
        logic signed [31:0] angle;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic walk;
        logic load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_poll;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/can_motor_feedback_and_drive_frames_unit.sv
// Motor feedback table and CAN drive frame packer, one word in, one word out.
// An accepted item is registered, executed in S_EXEC and loaded into the output
// register in S_LOAD; a poll tick adds S_WALK between the two, since the angle
// update walks the motor table one entry per cycle through a single adder. The
// input stalls from acceptance until the load, so the next item is taken only
// once the last one is loaded. The next item is accepted while a finished result
// still waits in the output register; a second finished result then holds the
// controller, and the input stalls, until the first one is taken. max_current
// resets to 16384 and may be written at any time the block is idle.
// Depends on cmfd_pkg, cmfd_ctrl and cmfd_dp.

module can_motor_feedback_and_drive_frames_unit
    import cmfd_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    cmfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    cmfd_dp #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

>>> rtl/cmfd_ctrl.sv
// Sequencing state machine of the motor feedback and drive frame unit.
// Depends on cmfd_pkg and the assertion macro header.
`include "can_motor_feedback_and_drive_frames_unit_macros.svh"

module cmfd_ctrl
    import cmfd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;

    always_comb begin
        n_state    = r_state;
        n_in_stall = r_in_stall;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state    = S_EXEC;
                    n_in_stall = 1'b1;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.is_poll ? S_WALK : S_LOAD;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // hold until the output register can take the word
                o_cmd.load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state    = S_IDLE;
                    n_in_stall = 1'b0;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;

    `CMFD_ASSERT_NEXT(a_accept_then_exec, i_clk, i_rst_n, o_cmd.latch, o_cmd.exec)
    `CMFD_ASSERT_NEXT(a_load_then_ready, i_clk, i_rst_n, o_cmd.load, !o_in_stall)
    `CMFD_ASSERT_NOW(a_stall_while_busy, i_clk, i_rst_n, o_cmd.exec || o_cmd.walk, o_in_stall)

endmodule

>>> rtl/cmfd_dp.sv
// Datapath: motor table, command frames, drive clamp and output register.
// Depends on cmfd_pkg and the assertion macro header.
`include "can_motor_feedback_and_drive_frames_unit_macros.svh"

module cmfd_dp
    import cmfd_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_word    i_in_word,
    input  logic        i_cfg_wr,
    input  logic [14:0] i_cfg_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    localparam int IDX_W = $clog2(MOTOR_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MOTOR_COUNT - 1);
    localparam logic [10:0] FB_TOP   = FEEDBACK_BASE + 11'(MOTOR_COUNT);
    localparam logic [3:0]  MOTOR_TOP = 4'(MOTOR_COUNT);

    t_in_word    r_item;
    logic [14:0] r_max_current;

    logic [15:0] r_speed [MOTOR_COUNT];
    logic [15:0] r_current [MOTOR_COUNT];
    logic [7:0]  r_temp [MOTOR_COUNT];
    logic [31:0] r_angle [MOTOR_COUNT];
    logic [63:0] r_wheel;
    logic [63:0] r_clamp;

    logic [IDX_W-1:0] r_walk_idx;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic             r_out_valid;
    t_out_word        r_out_word;
    t_out_word        n_out_word;

    // Decode of the held item
    logic [10:0]        id_off;
    logic [IDX_W-1:0]   fb_idx;
    logic               id_ok;
    logic [3:0]         wheel_off;
    logic [3:0]         clamp_off;
    logic               wheel_ok;
    logic               clamp_ok;
    logic               q_ok;
    logic [IDX_W-1:0]   q_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [15:0]        rd_speed;
    logic signed [15:0] lim;
    logic signed [15:0] neg_lim;
    logic signed [15:0] drive_sat;
    logic               out_taken;

    assign id_off    = r_item.frame_id - (FEEDBACK_BASE + 11'd1);
    assign fb_idx    = id_off[IDX_W-1:0];
    assign id_ok     = (r_item.frame_id > FEEDBACK_BASE) && (r_item.frame_id <= FB_TOP);
    assign wheel_off = r_item.motor - 4'd1;
    assign clamp_off = r_item.motor - (WHEEL_GROUP + 4'd1);
    assign wheel_ok  = (r_item.motor >= 4'd1) && (r_item.motor <= WHEEL_GROUP);
    assign clamp_ok  = (r_item.motor > WHEEL_GROUP) && (r_item.motor <= MOTOR_TOP);
    assign q_ok      = (r_item.motor >= 4'd1) && (r_item.motor <= MOTOR_TOP);
    assign q_idx     = wheel_off[IDX_W-1:0];

    // One read address of the speed table: the walk index during a poll, else the queried motor
    assign rd_idx   = i_cmd.walk ? r_walk_idx : q_idx;
    assign rd_speed = r_speed[rd_idx];

    assign lim     = signed'({1'b0, r_max_current});
    assign neg_lim = -lim;

    always_comb begin
        drive_sat = r_item.drive_value;
        if (r_item.drive_value > lim) begin
            drive_sat = lim;
        end else if (r_item.drive_value < neg_lim) begin
            drive_sat = neg_lim;
        end
    end

    always_comb begin
        n_status = ST_DONE;
        unique case (r_item.command)
            CMD_FRAME: begin
                if (!id_ok) begin
                    n_status = ST_BAD_ID;
                end else if (r_item.frame_length != FRAME_BYTES) begin
                    n_status = ST_BAD_LEN;
                end
            end
            CMD_WHEEL: n_status = wheel_ok ? ST_DONE : ST_RANGE;
            CMD_CLAMP: n_status = clamp_ok ? ST_DONE : ST_RANGE;
            default:   n_status = ST_DONE;
        endcase
    end

    always_comb begin
        n_out_word        = '0;
        n_out_word.status = r_status;
        if (r_item.command == CMD_TX_WHEEL) begin
            n_out_word.frame_valid    = 1'b1;
            n_out_word.out_frame_id   = WHEEL_ID;
            n_out_word.out_frame_data = r_wheel;
        end else if (r_item.command == CMD_TX_CLAMP) begin
            n_out_word.frame_valid    = 1'b1;
            n_out_word.out_frame_id   = CLAMP_ID;
            n_out_word.out_frame_data = r_clamp;
        end
        if (r_item.query) begin
            if (q_ok) begin
                n_out_word.speed          = signed'(rd_speed);
                n_out_word.torque_current = r_current[q_idx];
                n_out_word.temperature    = r_temp[q_idx];
                n_out_word.angle          = signed'(r_angle[q_idx]);
            end else if (r_status == ST_DONE) begin
                n_out_word.status = ST_RANGE;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_word;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.load) begin
            r_out_word <= n_out_word;
        end
    end

    // Tables, frames and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_speed[k]   <= '0;
                r_current[k] <= '0;
                r_temp[k]    <= '0;
                r_angle[k]   <= '0;
            end
            r_wheel       <= '0;
            r_clamp       <= '0;
            r_max_current <= MAX_CURRENT_RESET;
            r_walk_idx    <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_max_current <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_walk_idx <= '0;
                if (r_item.command == CMD_FRAME && n_status == ST_DONE) begin
                    r_speed[fb_idx]   <= r_item.frame_data[47:32];
                    r_current[fb_idx] <= r_item.frame_data[31:16];
                    r_temp[fb_idx]    <= r_item.frame_data[15:8];
                end
                if (r_item.command == CMD_WHEEL && wheel_ok) begin
                    r_wheel[(2'd3 - wheel_off[1:0]) * 16 +: 16] <= drive_sat;
                end
                if (r_item.command == CMD_CLAMP && clamp_ok) begin
                    r_clamp[(2'd3 - clamp_off[1:0]) * 16 +: 16] <= drive_sat;
                end
            end
            if (i_cmd.walk) begin
                r_angle[rd_idx] <= r_angle[rd_idx] + {{16{rd_speed[15]}}, rd_speed};
                // advance, wrap to zero after the last motor
                r_walk_idx <= (r_walk_idx == LAST_IDX) ? '0 : r_walk_idx + 1'b1;
            end
        end
    end

    assign out_taken = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.is_poll   = (r_item.command == CMD_POLL);
    assign o_stat.walk_last = (r_walk_idx == LAST_IDX);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `CMFD_ASSERT_NEXT(a_walk_wraps, i_clk, i_rst_n, i_cmd.walk && o_stat.walk_last, r_walk_idx == '0)
    `CMFD_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, i_cmd.load, r_out_valid)
    `CMFD_ASSERT_NOW(a_frame_id_known, i_clk, i_rst_n, r_out_valid && r_out_word.frame_valid, r_out_word.out_frame_id == WHEEL_ID || r_out_word.out_frame_id == CLAMP_ID)

endmodule
